>>> hdl/fixed_point_17_14_alu_defines.svh
// ---------------------------------------------------------------------------
// fixed_point_17_14_alu_defines
// Assertion macros for the fixed-point ALU.
// ---------------------------------------------------------------------------
`ifndef FIXED_POINT_17_14_ALU_DEFINES_SVH
`define FIXED_POINT_17_14_ALU_DEFINES_SVH

// Assert that a condition implies a consequence in the same cycle.
`define FXA_ASSERT_IMP(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// Assert that a condition implies a consequence in the following cycle.
`define FXA_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/fxa_pkg.sv
// ---------------------------------------------------------------------------
// fxa_pkg
// Shared types, opcodes and constants of the fixed-point ALU.
// ---------------------------------------------------------------------------
package fxa_pkg;

  localparam int DATA_W        = 32;
  localparam int CMD_W         = 4;
  localparam int FRAC_BITS_DEF = 14;

  typedef enum logic [CMD_W-1:0] {
    CMD_ITOF  = 4'd0,
    CMD_TRUNC = 4'd1,
    CMD_ROUND = 4'd2,
    CMD_ADDFF = 4'd3,
    CMD_ADDFI = 4'd4,
    CMD_SUBFF = 4'd5,
    CMD_SUBFI = 4'd6,
    CMD_MULFF = 4'd7,
    CMD_MULFI = 4'd8,
    CMD_DIVFF = 4'd9,
    CMD_DIVFI = 4'd10
  } cmd_t;

  // Result source selected at the end of the pipe.
  typedef enum logic [1:0] {
    SRC_NONE = 2'd0,
    SRC_SIMPLE = 2'd1,
    SRC_MUL = 2'd2,
    SRC_DIV = 2'd3
  } src_t;

  typedef struct packed {
    logic                valid;
    src_t                src;
    logic                dz;
    logic [DATA_W-1:0]   simple;
  } ctl_t;

endpackage

>>> hdl/fixed_point_17_14_alu.sv
// ---------------------------------------------------------------------------
// fixed_point_17_14_alu
// Pipelined signed 17.14 fixed-point ALU: conversions, add, sub, mul, div.
// ---------------------------------------------------------------------------
//   channel  handshake        payload
//   input    start & !busy    in_command, in_operand_a, in_operand_b
//   result   out_valid pulse  out_result, out_divide_by_zero
//
// One item may enter every cycle; the delay from the accepting edge to the
// result is set by the divider pipe (input register, four quotient bits per
// stage, output register). All commands share that latency so results leave
// in order. busy is always low; nothing stalls.
// rst_n clears only the valid bits.
`include "fixed_point_17_14_alu_defines.svh"

module fixed_point_17_14_alu #(
  parameter int FRAC_BITS = fxa_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [fxa_pkg::CMD_W-1:0]         in_command,
  input  logic signed [fxa_pkg::DATA_W-1:0] in_operand_a,
  input  logic signed [fxa_pkg::DATA_W-1:0] in_operand_b,
  output logic                              out_valid,
  output logic signed [fxa_pkg::DATA_W-1:0] out_result,
  output logic                              out_divide_by_zero
);
  import fxa_pkg::*;

  localparam int STEPS   = 4;
  localparam int LATENCY = 1 + (2 * DATA_W) / STEPS + 1;

  ctl_t              dec_ctl;
  ctl_t              ctl_r   [LATENCY];
  ctl_t              ctl_nxt [LATENCY];
  logic              mul_signed;
  logic [DATA_W-1:0] num_hi, num_lo;
  logic [DATA_W-1:0] mul_p, div_q;
  logic [DATA_W-1:0] result_r;
  logic              dz_r, valid_r;
  logic [DATA_W-1:0] result_nxt;

  assign busy = 1'b0;

  fxa_decode #(.FRAC_BITS(FRAC_BITS)) u_dec (
    .cmd(in_command), .a(in_operand_a), .b(in_operand_b), .ctl(dec_ctl),
    .mul_signed(mul_signed), .div_num_hi(num_hi), .div_num_lo(num_lo)
  );

  fxa_mul #(.FRAC_BITS(FRAC_BITS), .LAT(LATENCY)) u_mul (
    .clk(clk), .shift_en(mul_signed), .a(in_operand_a), .b(in_operand_b),
    .p(mul_p)
  );

  fxa_div #(.STEPS_PER(STEPS)) u_div (
    .clk(clk), .num_hi(num_hi), .num_lo(num_lo), .den(in_operand_b), .q(div_q)
  );

  // Carry control alongside the datapath; drop valid bits in reset.
  always_comb begin
    ctl_nxt[0] = dec_ctl;
    ctl_nxt[0].valid = start & ~busy;
    for (int i = 1; i < LATENCY; i++) begin
      ctl_nxt[i] = ctl_r[i-1];
    end
    if (!rst_n) begin
      for (int i = 0; i < LATENCY; i++) begin
        ctl_nxt[i].valid = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < LATENCY; i++) begin
      ctl_r[i] <= ctl_nxt[i];
    end
  end

  always_comb begin
    unique case (ctl_r[LATENCY-1].src)
      SRC_SIMPLE: result_nxt = ctl_r[LATENCY-1].simple;
      SRC_MUL:    result_nxt = mul_p;
      SRC_DIV:    result_nxt = div_q;
      default:    result_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ctl_r[LATENCY-1].valid;
    end
    result_r <= result_nxt;
    dz_r     <= ctl_r[LATENCY-1].dz;
  end

  assign out_valid          = valid_r;
  assign out_result         = result_r;
  assign out_divide_by_zero = dz_r;

  `FXA_ASSERT_IMP(a_dz_zero, clk, rst_n, valid_r && dz_r, result_r == '0, "dz result not 0")
  `FXA_ASSERT_NEXT(a_last_valid, clk, rst_n, ctl_r[LATENCY-1].valid, out_valid, "item lost")
  `FXA_ASSERT_IMP(a_never_busy, clk, rst_n, 1'b1, !busy, "busy raised")
endmodule

>>> hdl/fxa_decode.sv
// ---------------------------------------------------------------------------
// fxa_decode
// Decode the command and prepare simple results and multiplier/divider
// operands.
// ---------------------------------------------------------------------------
module fxa_decode #(
  parameter int FRAC_BITS = fxa_pkg::FRAC_BITS_DEF
) (
  input  logic [fxa_pkg::CMD_W-1:0]   cmd,
  input  logic [fxa_pkg::DATA_W-1:0]  a,
  input  logic [fxa_pkg::DATA_W-1:0]  b,
  output fxa_pkg::ctl_t               ctl,
  output logic                        mul_signed,
  output logic [fxa_pkg::DATA_W-1:0]  div_num_hi,
  output logic [fxa_pkg::DATA_W-1:0]  div_num_lo
);
  import fxa_pkg::*;

  localparam logic [DATA_W-1:0] HALF = DATA_W'(1) << (FRAC_BITS - 1);

  logic [DATA_W:0]   rnd_wide;
  logic [63:0]       num;

  function automatic logic [DATA_W-1:0] trunc_shift(input logic [DATA_W:0] v);
    logic [DATA_W:0] m;
    logic [DATA_W:0] q;
    m = v[DATA_W] ? (~v + 1'b1) : v;
    q = m >> FRAC_BITS;
    trunc_shift = v[DATA_W] ? DATA_W'(~q + 1'b1) : DATA_W'(q);
  endfunction

  always_comb begin
    rnd_wide = a[DATA_W-1] ? ({a[DATA_W-1], a} - {1'b0, HALF})
                           : ({a[DATA_W-1], a} + {1'b0, HALF});
    num = {{(64-DATA_W){a[DATA_W-1]}}, a};
    if (cmd == CMD_DIVFF) begin
      num = num << FRAC_BITS;
    end
    div_num_hi = num[63:32];
    div_num_lo = num[31:0];
    mul_signed = (cmd == CMD_MULFF);
    ctl.valid = 1'b0;
    ctl.dz = 1'b0;
    ctl.src = SRC_SIMPLE;
    ctl.simple = '0;
    unique case (cmd)
      CMD_ITOF:  ctl.simple = a << FRAC_BITS;
      CMD_TRUNC: ctl.simple = trunc_shift({a[DATA_W-1], a});
      CMD_ROUND: ctl.simple = trunc_shift(rnd_wide);
      CMD_ADDFF: ctl.simple = a + b;
      CMD_ADDFI: ctl.simple = a + (b << FRAC_BITS);
      CMD_SUBFF: ctl.simple = a - b;
      CMD_SUBFI: ctl.simple = a - (b << FRAC_BITS);
      CMD_MULFF, CMD_MULFI: ctl.src = SRC_MUL;
      CMD_DIVFF, CMD_DIVFI: begin
        if (b == '0) begin
          ctl.dz = 1'b1;
          ctl.src = SRC_NONE;
        end else begin
          ctl.src = SRC_DIV;
        end
      end
      default: ctl.src = SRC_NONE;
    endcase
  end
endmodule

>>> hdl/fxa_mul.sv
// ---------------------------------------------------------------------------
// fxa_mul
// Pipelined 32x32 signed multiplier with optional fraction shift, fixed latency.
// ---------------------------------------------------------------------------
module fxa_mul #(
  parameter int FRAC_BITS = fxa_pkg::FRAC_BITS_DEF,
  parameter int LAT       = 4
) (
  input  logic                        clk,
  input  logic                        shift_en,
  input  logic [fxa_pkg::DATA_W-1:0]  a,
  input  logic [fxa_pkg::DATA_W-1:0]  b,
  output logic [fxa_pkg::DATA_W-1:0]  p
);
  import fxa_pkg::*;

  // Stage 1: register operands. Stage 2: multiply. Then shift and delay.
  logic [DATA_W-1:0]   a_r, b_r;
  logic                sh_r, sh2_r;
  logic signed [63:0]  prod_r;
  logic [DATA_W-1:0]   res_r [LAT-2];

  always_ff @(posedge clk) begin
    a_r    <= a;
    b_r    <= b;
    sh_r   <= shift_en;
    prod_r <= $signed(a_r) * $signed(b_r);
    sh2_r  <= sh_r;
    res_r[0] <= sh2_r ? DATA_W'(prod_r >>> FRAC_BITS) : prod_r[DATA_W-1:0];
    for (int i = 1; i < LAT-2; i++) begin
      res_r[i] <= res_r[i-1];
    end
  end

  assign p = res_r[LAT-3];
endmodule

>>> hdl/fxa_div.sv
// ---------------------------------------------------------------------------
// fxa_div
// Pipelined signed divider: 64-bit dividend by 32-bit divisor, truncating,
// radix-2 restoring, STEPS_PER quotient bits per stage.
// ---------------------------------------------------------------------------
module fxa_div #(
  parameter int STEPS_PER = 4
) (
  input  logic                        clk,
  input  logic [fxa_pkg::DATA_W-1:0]  num_hi,
  input  logic [fxa_pkg::DATA_W-1:0]  num_lo,
  input  logic [fxa_pkg::DATA_W-1:0]  den,
  output logic [fxa_pkg::DATA_W-1:0]  q
);
  import fxa_pkg::*;

  localparam int NW     = 2 * DATA_W;
  localparam int STAGES = NW / STEPS_PER;

  logic [NW-1:0]     n_abs;
  logic [DATA_W-1:0] d_abs;
  logic [NW-1:0]     num;

  // Per stage: partial remainder, shifting dividend/quotient, divisor, sign.
  logic [DATA_W:0]   rem_r  [STAGES+1];
  logic [NW-1:0]     qn_r   [STAGES+1];
  logic [DATA_W-1:0] d_r    [STAGES+1];
  logic              neg_r  [STAGES+1];
  logic [DATA_W-1:0] q_r;

  assign num   = {num_hi, num_lo};
  assign n_abs = num[NW-1] ? (~num + 1'b1) : num;
  assign d_abs = den[DATA_W-1] ? (~den + 1'b1) : den;

  always_ff @(posedge clk) begin
    rem_r[0] <= '0;
    qn_r[0]  <= n_abs;
    d_r[0]   <= d_abs;
    neg_r[0] <= num[NW-1] ^ den[DATA_W-1];
  end

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [DATA_W:0] rem_c [STEPS_PER+1];
    logic [NW-1:0]   qn_c  [STEPS_PER+1];
    logic [DATA_W+1:0] trial;
    always_comb begin
      trial = '0;
      rem_c[0] = rem_r[s];
      qn_c[0]  = qn_r[s];
      for (int k = 0; k < STEPS_PER; k++) begin
        trial = {rem_c[k], qn_c[k][NW-1]} - {2'b00, d_r[s]};
        if (!trial[DATA_W+1]) begin
          rem_c[k+1] = trial[DATA_W:0];
          qn_c[k+1]  = {qn_c[k][NW-2:0], 1'b1};
        end else begin
          rem_c[k+1] = {rem_c[k][DATA_W-1:0], qn_c[k][NW-1]};
          qn_c[k+1]  = {qn_c[k][NW-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      rem_r[s+1] <= rem_c[STEPS_PER];
      qn_r[s+1]  <= qn_c[STEPS_PER];
      d_r[s+1]   <= d_r[s];
      neg_r[s+1] <= neg_r[s];
    end
  end

  always_ff @(posedge clk) begin
    q_r <= neg_r[STAGES] ? DATA_W'(~qn_r[STAGES] + 1'b1) : qn_r[STAGES][DATA_W-1:0];
  end

  assign q = q_r;
endmodule

>>> verif/fixed_point_17_14_alu_test.sv
// ---------------------------------------------------------------------------
// fixed_point_17_14_alu_test
// Self-checking bench for the 17.14 ALU: directed corner items, then random
// items under three idle patterns, each result checked against a predictor.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module fixed_point_17_14_alu_test;
  import fxa_pkg::*;

  localparam int FB        = 14;
  localparam int LATENCY   = 19;
  localparam int MAX_CYCLE = 200000;

  typedef struct {
    logic [3:0]  cmd;
    logic [31:0] a;
    logic [31:0] b;
  } alu_item_t;

  typedef struct {
    logic [31:0] res;
    logic        dz;
  } alu_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [3:0] in_command = '0;
  logic signed [31:0] in_operand_a = '0;
  logic signed [31:0] in_operand_b = '0;
  logic out_valid;
  logic signed [31:0] out_result;
  logic out_divide_by_zero;

  alu_item_t   pending_items[$];
  alu_result_t expected_results[$];
  int  send_idle_pct = 0;
  bit  hold_send = 1'b0;
  bit  failed = 1'b0;
  int  cycle_count = 0;

  fixed_point_17_14_alu uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_operand_a(in_operand_a),
    .in_operand_b(in_operand_b), .out_valid(out_valid),
    .out_result(out_result), .out_divide_by_zero(out_divide_by_zero)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shift a signed value right by FB, truncating toward zero.
  function automatic longint shr_toward_zero(longint v);
    if (v < 0) return -((-v) >>> FB);
    return v >>> FB;
  endfunction

  function automatic alu_result_t compute_alu(alu_item_t it);
    alu_result_t r;
    longint a;
    longint b;
    longint half;
    longint q;
    a = longint'(signed'(it.a));
    b = longint'(signed'(it.b));
    half = longint'(1) << (FB - 1);
    r.res = '0;
    r.dz = 1'b0;
    case (it.cmd)
      CMD_ITOF:  r.res = 32'(a << FB);
      CMD_TRUNC: r.res = 32'(shr_toward_zero(a));
      CMD_ROUND: r.res = 32'(shr_toward_zero(a < 0 ? a - half : a + half));
      CMD_ADDFF: r.res = 32'(a + b);
      CMD_ADDFI: r.res = 32'(a + (b << FB));
      CMD_SUBFF: r.res = 32'(a - b);
      CMD_SUBFI: r.res = 32'(a - (b << FB));
      CMD_MULFF: r.res = 32'((a * b) >>> FB);
      CMD_MULFI: r.res = 32'(a * b);
      CMD_DIVFF, CMD_DIVFI: begin
        if (b == 0) begin
          r.dz = 1'b1;
        end else begin
          q = ((it.cmd == CMD_DIVFF) ? (a << FB) : a) / b;
          r.res = 32'(q);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'(signed'($urandom_range(0, 8)) - 4);
      3: return 32'(signed'($urandom_range(0, 65535)) - 32768) << FB;
      4: return 32'(signed'($urandom_range(0, 131071)) - 65536);
      5: return 32'(signed'($urandom_range(0, 2000)) - 1000);
      default: return $urandom;
    endcase
  endfunction

  task automatic add_item(logic [3:0] c, logic [31:0] a, logic [31:0] b);
    alu_item_t it;
    it.cmd = c;
    it.a = a;
    it.b = b;
    pending_items.push_back(it);
  endtask

  task automatic add_random(int n);
    int k;
    logic [3:0] c;
    for (k = 0; k < n; k++) begin
      c = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
                                       : 4'($urandom_range(0, 10));
      add_item(c, pick_operand(),
               ($urandom_range(0, 15) == 0) ? 32'd0 : pick_operand());
    end
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || expected_results.size() != 0)
      @(posedge clk);
  endtask

  // Driver: present the next item unless idling, advance on acceptance.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) void'(pending_items.pop_front());
      if (pending_items.size() > 0 && !hold_send &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        alu_item_t nx;
        nx = pending_items[0];
        start <= 1'b1;
        in_command <= nx.cmd;
        in_operand_a <= nx.a;
        in_operand_b <= nx.b;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Record the expectation for each accepted item; check each result.
  always @(posedge clk) begin
    alu_item_t it;
    alu_result_t exp_r;
    cycle_count <= cycle_count + 1;
    if (rst_n && start && !busy) begin
      it.cmd = in_command;
      it.a = in_operand_a;
      it.b = in_operand_b;
      expected_results.push_back(compute_alu(it));
    end
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h dz %b", $time, out_result,
                 out_divide_by_zero);
        failed = 1'b1;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_result !== exp_r.res) begin
          $display("%0t: result expected %h actual %h", $time, exp_r.res, out_result);
          failed = 1'b1;
        end
        if (out_divide_by_zero !== exp_r.dz) begin
          $display("%0t: divide_by_zero expected %b actual %b", $time, exp_r.dz,
                   out_divide_by_zero);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    int c;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed corners
    add_item(CMD_ITOF, 32'h8000_0000, 32'hffff_ffff);
    add_item(CMD_ITOF, 32'h7fff_ffff, 32'h0);
    add_item(CMD_TRUNC, 32'hffff_c001, 32'h0);
    add_item(CMD_TRUNC, 32'h8000_0000, 32'h0);
    add_item(CMD_ROUND, 32'h0000_2000, 32'h0);
    add_item(CMD_ROUND, 32'hffff_e000, 32'h0);
    add_item(CMD_ROUND, 32'h7fff_ffff, 32'h0);
    add_item(CMD_ROUND, 32'h8000_0000, 32'h0);
    add_item(CMD_ADDFF, 32'h7fff_ffff, 32'h1);
    add_item(CMD_ADDFI, 32'h1, 32'h8000_0000);
    add_item(CMD_SUBFF, 32'h8000_0000, 32'h1);
    add_item(CMD_SUBFI, 32'h0, 32'h7fff_ffff);
    add_item(CMD_MULFF, 32'h8000_0000, 32'h8000_0000);
    add_item(CMD_MULFF, 32'hffff_ffff, 32'h1);
    add_item(CMD_MULFI, 32'h7fff_ffff, 32'h7fff_ffff);
    add_item(CMD_DIVFF, 32'h8000_0000, 32'hffff_ffff);
    add_item(CMD_DIVFF, 32'h1234_5678, 32'h0);
    add_item(CMD_DIVFI, 32'h8000_0000, 32'hffff_ffff);
    add_item(CMD_DIVFI, 32'hffff_fff9, 32'h2);
    add_item(CMD_DIVFI, 32'h5, 32'h0);
    for (c = 11; c < 16; c++) add_item(4'(c), 32'hffff_ffff, 32'h0);
    send_idle_pct = 13;
    wait_drained();

    // sender held while random items queue up, then released
    hold_send = 1'b1;
    add_random(20);
    repeat (30) @(posedge clk);
    hold_send = 1'b0;
    wait_drained();

    add_random(260);
    wait_drained();
    send_idle_pct = 78;
    add_random(260);
    wait_drained();
    send_idle_pct = 0;
    add_random(260);
    wait_drained();
    repeat (LATENCY + 5) @(posedge clk);

    if (!failed) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    wait (cycle_count >= MAX_CYCLE);
    $display("FAIL");
    $finish;
  end

endmodule
